### src/ipc_pkg.sv
`default_nettype none

package ipc_pkg;

    localparam int VALUE_BITS_DEF = 8;
    localparam int DISTINCT_BITS = 3;
    localparam int SPHENIC_FACTORS = 3;
    localparam int FIRST_TRIAL = 2;

    typedef enum logic
    {
        SRC_VALUE = 1'b0,
        SRC_REST  = 1'b1
    } ipc_div_src_t;

    typedef struct packed
    {
        logic         load;
        logic         div_start;
        ipc_div_src_t div_src;
        logic         trial_update;
        logic         a_reset;
        logic         fact_first;
        logic         fact_second;
        logic         out_load;
    } ipc_cmd_t;

    typedef struct packed
    {
        logic div_done;
        logic rem_zero;
        logic trial_more;
        logic fact_more;
        logic repeat_seen;
    } ipc_status_t;

endpackage

`default_nettype wire

### src/ipc_if.sv
`default_nettype none

interface ipc_in_if import ipc_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) ();
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink (input valid, input value, output ready);
endinterface

interface ipc_out_if ();
    logic valid;
    logic ready;
    logic is_perfect;
    logic is_prime;
    logic is_square;
    logic is_sphenic;

    modport source (output valid, output is_perfect, output is_prime, output is_square,
                    output is_sphenic, input ready);
    modport sink (input valid, input is_perfect, input is_prime, input is_square,
                  input is_sphenic, output ready);
endinterface

`default_nettype wire

### src/ipc_divider.sv
`default_nettype none

module ipc_divider import ipc_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [VALUE_BITS-1:0] dividend,
    input  logic [VALUE_BITS-1:0] divisor,
    output logic                  busy,
    output logic                  done,
    output logic [VALUE_BITS-1:0] quotient,
    output logic [VALUE_BITS-1:0] remainder
);

    localparam int CW = $clog2(VALUE_BITS);

    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [VALUE_BITS-1:0] quo_reg, quo_next;
    logic [VALUE_BITS-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [VALUE_BITS:0]   trial;
    logic [VALUE_BITS:0]   diff;

    assign trial = {rem_reg, quo_reg[VALUE_BITS-1]};
    assign diff  = trial - {1'b0, dvs_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            // one quotient bit per cycle
            if (!diff[VALUE_BITS])
            begin
                rem_next = diff[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[VALUE_BITS-1:0];
                quo_next = {quo_reg[VALUE_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(VALUE_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_done_timing: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##(VALUE_BITS + 1) done_reg)
        else $error("divider done not on time");

endmodule

`default_nettype wire

### src/ipc_datapath.sv
`default_nettype none

module ipc_datapath import ipc_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [VALUE_BITS-1:0] value,
    input  ipc_cmd_t              cmd,
    output ipc_status_t           status,
    output logic                  is_perfect,
    output logic                  is_prime,
    output logic                  is_square,
    output logic                  is_sphenic
);

    localparam logic [VALUE_BITS-1:0] ONE = VALUE_BITS'(1);
    localparam logic [VALUE_BITS-1:0] TWO = VALUE_BITS'(FIRST_TRIAL);

    logic [VALUE_BITS-1:0]    value_reg;
    logic [VALUE_BITS-1:0]    a_reg;
    logic [VALUE_BITS-1:0]    rest_reg;
    logic [VALUE_BITS:0]      sum_reg;
    logic                     over_reg;
    logic                     found_reg;
    logic                     square_reg;
    logic                     repeat_reg;
    logic [DISTINCT_BITS-1:0] distinct_reg;
    logic                     perfect_out_reg;
    logic                     prime_out_reg;
    logic                     square_out_reg;
    logic                     sphenic_out_reg;

    logic [2*VALUE_BITS-1:0]  a_sq;
    logic [VALUE_BITS:0]      sum_add;
    logic [DISTINCT_BITS-1:0] distinct_final;
    logic                     rest_gt_one;
    logic [VALUE_BITS-1:0]    div_dividend;
    logic                     div_busy;
    logic                     div_done;
    logic [VALUE_BITS-1:0]    div_quo;
    logic [VALUE_BITS-1:0]    div_rem;
    logic                     rem_zero;

    assign div_dividend = (cmd.div_src == SRC_REST) ? rest_reg : value_reg;

    ipc_divider #(
        .VALUE_BITS (VALUE_BITS)
    ) u_divider (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (a_reg),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign a_sq           = a_reg * a_reg;
    assign rem_zero       = (div_rem == '0);
    assign sum_add        = sum_reg + {1'b0, a_reg};
    assign rest_gt_one    = (rest_reg > ONE);
    assign distinct_final = distinct_reg + {{(DISTINCT_BITS-1){1'b0}}, rest_gt_one};

    assign status.div_done    = div_done;
    assign status.rem_zero    = rem_zero;
    assign status.trial_more  = (a_reg <= (value_reg >> 1));
    assign status.fact_more   = (a_sq <= {{VALUE_BITS{1'b0}}, rest_reg});
    assign status.repeat_seen = repeat_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg    <= value;
            a_reg        <= TWO;
            rest_reg     <= value;
            sum_reg      <= {1'b0, ONE};
            over_reg     <= 1'b0;
            found_reg    <= 1'b0;
            square_reg   <= (value == ONE);
            repeat_reg   <= 1'b0;
            distinct_reg <= '0;
        end
        if (cmd.a_reset)
        begin
            a_reg <= TWO;
        end
        if (cmd.trial_update)
        begin
            if (rem_zero)
            begin
                found_reg <= 1'b1;
                // sum stays at or below the value, overflow is sticky
                if (sum_add > {1'b0, value_reg})
                begin
                    over_reg <= 1'b1;
                end
                else
                begin
                    sum_reg <= sum_add;
                end
            end
            if (a_sq == {{VALUE_BITS{1'b0}}, value_reg})
            begin
                square_reg <= 1'b1;
            end
            a_reg <= a_reg + ONE;
        end
        if (cmd.fact_first)
        begin
            if (rem_zero)
            begin
                rest_reg     <= div_quo;
                distinct_reg <= distinct_reg + DISTINCT_BITS'(1);
            end
            else
            begin
                a_reg <= a_reg + ONE;
            end
        end
        if (cmd.fact_second)
        begin
            if (rem_zero)
            begin
                repeat_reg <= 1'b1;
            end
            a_reg <= a_reg + ONE;
        end
        if (cmd.out_load)
        begin
            perfect_out_reg <= (value_reg > ONE) && !over_reg && (sum_reg == {1'b0, value_reg});
            prime_out_reg   <= (value_reg > ONE) && !found_reg;
            square_out_reg  <= square_reg;
            sphenic_out_reg <= (value_reg > ONE) && !repeat_reg
                               && (distinct_final == DISTINCT_BITS'(SPHENIC_FACTORS));
        end
    end

    assign is_perfect = perfect_out_reg;
    assign is_prime   = prime_out_reg;
    assign is_square  = square_out_reg;
    assign is_sphenic = sphenic_out_reg;

    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy && !div_done)
        else $error("division requested while divider active");

    a_prime_not_perfect: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |=> !(prime_out_reg && perfect_out_reg))
        else $error("item flagged both prime and perfect");

endmodule

`default_nettype wire

### src/ipc_controller.sv
`default_nettype none

module ipc_controller import ipc_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    output logic        out_valid,
    input  logic        out_ready,
    input  ipc_status_t status,
    output ipc_cmd_t    cmd
);

    typedef enum logic [7:0]
    {
        S_IDLE    = 8'b0000_0001,
        S_TCHK    = 8'b0000_0010,
        S_TWAIT   = 8'b0000_0100,
        S_FCHK    = 8'b0000_1000,
        S_FWAIT1  = 8'b0001_0000,
        S_FSTART2 = 8'b0010_0000,
        S_FWAIT2  = 8'b0100_0000,
        S_FIN     = 8'b1000_0000
    } ipc_state_t;

    ipc_state_t state_reg, state_next;
    logic       out_valid_reg, out_valid_next;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_TCHK;
                end
            end
            S_TCHK:
            begin
                // trial division up to half the value
                if (status.trial_more)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = SRC_VALUE;
                    state_next    = S_TWAIT;
                end
                else
                begin
                    cmd.a_reset = 1'b1;
                    state_next  = S_FCHK;
                end
            end
            S_TWAIT:
            begin
                cmd.div_src = SRC_VALUE;
                if (status.div_done)
                begin
                    cmd.trial_update = 1'b1;
                    state_next       = S_TCHK;
                end
            end
            S_FCHK:
            begin
                // factoring while p squared fits in the remaining cofactor and no repeated factor is seen
                if (status.fact_more && !status.repeat_seen)
                begin
                    cmd.div_start = 1'b1;
                    cmd.div_src   = SRC_REST;
                    state_next    = S_FWAIT1;
                end
                else
                begin
                    state_next = S_FIN;
                end
            end
            S_FWAIT1:
            begin
                cmd.div_src = SRC_REST;
                if (status.div_done)
                begin
                    cmd.fact_first = 1'b1;
                    state_next     = status.rem_zero ? S_FSTART2 : S_FCHK;
                end
            end
            S_FSTART2:
            begin
                cmd.div_start = 1'b1;
                cmd.div_src   = SRC_REST;
                state_next    = S_FWAIT2;
            end
            S_FWAIT2:
            begin
                cmd.div_src = SRC_REST;
                if (status.div_done)
                begin
                    cmd.fact_second = 1'b1;
                    state_next      = S_FCHK;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (state_reg == S_TCHK))
        else $error("accepted item did not start trial division");

    a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIN && out_valid_reg && !out_ready) |=> (state_reg == S_FIN))
        else $error("finished item overwrote a pending result");

endmodule

`default_nettype wire

### src/integer_property_classifier_top.sv
// sequence: trial division of value v by each a from 2 up to v/2, then factoring of the cofactor,
// trying each p while p*p fits in the cofactor, with a second division by p whenever p divides
// flow: one item at a time, a new item is taken only after the last one reaches the output register,
// all divisions use the shared restoring divider, one quotient bit per cycle
// a finished result waits in the output register while the next item is taken
// reset: rst_n asynchronous active low clears the controller and divider, no item pending
`default_nettype none

module integer_property_classifier_top import ipc_pkg::*; #(
    parameter int VALUE_BITS = VALUE_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    ipc_in_if.sink    in_ch,
    ipc_out_if.source out_ch
);

    ipc_cmd_t    cmd;
    ipc_status_t status;
    logic        out_valid;

    ipc_controller u_controller (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    ipc_datapath #(
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .value      (in_ch.value),
        .cmd        (cmd),
        .status     (status),
        .is_perfect (out_ch.is_perfect),
        .is_prime   (out_ch.is_prime),
        .is_square  (out_ch.is_square),
        .is_sphenic (out_ch.is_sphenic)
    );

    assign out_ch.valid = out_valid;

endmodule

`default_nettype wire
